### hw/rtl/aapd_pkg.sv
`timescale 1ns / 1ps

package aapd_pkg;

  // Default depth of the queue between the classifier and the packer.
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  // Armour character ranges and the decode constants.
  localparam logic [7:0] CHAR_LOW_A  = 8'd48;
  localparam logic [7:0] CHAR_HIGH_A = 8'd87;
  localparam logic [7:0] CHAR_LOW_B  = 8'd96;
  localparam logic [7:0] CHAR_HIGH_B = 8'd119;
  localparam logic [7:0] SIX_GAP_AT  = 8'd40;
  localparam logic [2:0] MAX_FILL    = 3'd5;

  // Status codes on the final result of a message.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
  localparam logic [1:0] STATUS_BAD_FILL = 2'd2;

  typedef struct packed {
    logic [7:0] armour_char;
    logic       end_of_message;
    logic [2:0] fill_count;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_result;
    logic [1:0] status;
  } out_item_t;

  // A character after classification, as the packer sees it.
  typedef struct packed {
    logic       char_ok;
    logic [5:0] six;
    logic       last;
    logic [2:0] fill;
  } cls_item_t;

  function automatic cls_item_t classify(input in_item_t item);
    cls_item_t  c;
    logic [7:0] v;
    v = item.armour_char - CHAR_LOW_A;
    if (v > SIX_GAP_AT) begin
      v = v - 8'd8;
    end
    c.char_ok = ((item.armour_char >= CHAR_LOW_A) && (item.armour_char <= CHAR_HIGH_A)) ||
                ((item.armour_char >= CHAR_LOW_B) && (item.armour_char <= CHAR_HIGH_B));
    c.six     = v[5:0];
    c.last    = item.end_of_message;
    c.fill    = item.fill_count;
    return c;
  endfunction

endpackage

### hw/rtl/ais_armour_payload_decode_unit.sv
`timescale 1ns / 1ps

// Channel  | Handshake            | Payload
// ---------+----------------------+--------------------------------------------
// input    | push / full          | item   : armour_char, end_of_message, fill_count
// result   | pop / empty          | result : data_byte, final_result, status
//
// A request passes through the front stage, the queue and the result register before its
// first byte is on the result ports, and the block sustains one character per cycle
// while results are popped as they appear. A character that closes a message and yields
// two bytes holds the packer until its second byte leaves the spare slot, because the
// result register drains one byte per cycle, and only on pop. Reset is synchronous and
// clears the pipeline, the queue and the packing state. A stalled result side fills the
// queue first; full rises only when the queue and the front stage are both occupied.
module ais_armour_payload_decode_unit
  import aapd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  item,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  // Classified characters between the front stage and the queue.
  logic      front_valid;
  logic      front_ready;
  cls_item_t front_item;

  // Classified characters between the queue and the packer.
  logic      queue_valid;
  logic      queue_take;
  cls_item_t queue_item;

  // The front stage checks the character range and turns it into six bits.
  aapd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cls_valid (front_valid),
    .cls_ready (front_ready),
    .cls_item  (front_item)
  );

  // The queue lets the front keep taking requests while the packer waits on pop.
  aapd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_item  (front_item),
    .rd_valid (queue_valid),
    .rd_take  (queue_take),
    .rd_item  (queue_item)
  );

  // The packer gathers six-bit groups into bytes, handles the fill bits and the
  // sticky error, and presents results through a result register and a spare slot.
  aapd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cls_valid (queue_valid),
    .cls_take  (queue_take),
    .cls_item  (queue_item),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

### hw/rtl/aapd_front.sv
`timescale 1ns / 1ps

module aapd_front
  import aapd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  item,
  output logic      cls_valid,
  input  logic      cls_ready,
  output cls_item_t cls_item
);

  logic      vld;
  cls_item_t held;

  // The stage takes a new character whenever it is empty or its content moves on.
  assign full      = vld && !cls_ready;
  assign cls_valid = vld;
  assign cls_item  = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (!full) begin
      vld <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (!full && push) begin
      held <= classify(item);
    end
  end

endmodule

### hw/rtl/aapd_queue.sv
`timescale 1ns / 1ps

module aapd_queue
  import aapd_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  cls_item_t wr_item,
  output logic      rd_valid,
  input  logic      rd_take,
  output cls_item_t rd_item
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cls_item_t        slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = (count != FULL_CNT);
  assign rd_valid = (count != '0);
  assign rd_item  = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_take && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end

endmodule

### hw/rtl/aapd_back.sv
`timescale 1ns / 1ps

module aapd_back
  import aapd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cls_valid,
  output logic      cls_take,
  input  cls_item_t cls_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  logic [6:0] acc;
  logic [2:0] held;
  logic [1:0] err;
  logic       out_vld;
  out_item_t  out_q;
  logic       spare_vld;
  out_item_t  spare_q;

  logic [6:0]  acc_next;
  logic [2:0]  held_next;
  logic [1:0]  err_next;
  logic [1:0]  res_cnt;
  out_item_t   r0;
  out_item_t   r1;
  logic [1:0]  err_now;
  logic [12:0] wide;
  logic [12:0] rem;
  logic [3:0]  held_sum;
  logic [3:0]  h_left;
  logic [2:0]  n_bits;
  logic        out_free;

  assign empty    = !out_vld;
  assign result   = out_q;
  assign out_free = !out_vld || pop;
  assign cls_take = cls_valid && out_free && !spare_vld;

  always_comb begin
    acc_next  = acc;
    held_next = held;
    err_next  = err;
    res_cnt   = 2'd0;
    r0        = '{data_byte: 8'd0, final_result: 1'b0, status: STATUS_OK};
    r1        = '{data_byte: 8'd0, final_result: 1'b1, status: STATUS_OK};
    wide      = '0;
    rem       = '0;
    held_sum  = '0;
    h_left    = '0;
    n_bits    = 3'd6 - cls_item.fill;
    err_now   = err;
    if ((err == STATUS_OK) && !cls_item.char_ok) begin
      err_now = STATUS_BAD_CHAR;
    end

    if (!cls_item.last) begin
      err_next = err_now;
      if (err_now == STATUS_OK) begin
        wide     = {acc, cls_item.six};
        held_sum = {1'b0, held} + 4'd6;
        h_left   = held_sum;
        if (held_sum >= 4'd8) begin
          h_left       = held_sum - 4'd8;
          r0.data_byte = 8'(wide >> h_left);
          res_cnt      = 2'd1;
        end
        acc_next  = 7'(wide & ((13'd1 << h_left) - 13'd1));
        held_next = h_left[2:0];
      end
    end else begin
      // The message ends here; all packing state returns to its reset values.
      acc_next  = '0;
      held_next = '0;
      err_next  = STATUS_OK;
      if (cls_item.fill > MAX_FILL) begin
        err_now = STATUS_BAD_FILL;
      end
      if (err_now != STATUS_OK) begin
        r0.final_result = 1'b1;
        r0.status       = err_now;
        res_cnt         = 2'd1;
      end else begin
        wide     = ({6'd0, acc} << n_bits) | {7'd0, cls_item.six >> cls_item.fill};
        held_sum = {1'b0, held} + {1'b0, n_bits};
        if (held_sum >= 4'd8) begin
          h_left          = held_sum - 4'd8;
          r0.data_byte    = 8'(wide >> h_left);
          r0.final_result = (h_left == 4'd0);
          rem             = wide & ((13'd1 << h_left) - 13'd1);
          if (h_left != 4'd0) begin
            r1.data_byte = 8'(rem << (4'd8 - h_left));
            res_cnt      = 2'd2;
          end else begin
            res_cnt = 2'd1;
          end
        end else begin
          r0.data_byte    = 8'(wide << (4'd8 - held_sum));
          r0.final_result = 1'b1;
          res_cnt         = 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      held      <= '0;
      err       <= STATUS_OK;
      out_vld   <= 1'b0;
      spare_vld <= 1'b0;
    end else begin
      if (cls_take) begin
        acc  <= acc_next;
        held <= held_next;
        err  <= err_next;
      end
      if (spare_vld) begin
        if (out_free) begin
          out_vld   <= 1'b1;
          spare_vld <= 1'b0;
        end
      end else if (cls_take) begin
        out_vld   <= (res_cnt != 2'd0);
        spare_vld <= (res_cnt == 2'd2);
      end else if (pop) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (spare_vld) begin
      if (out_free) begin
        out_q <= spare_q;
      end
    end else if (cls_take) begin
      out_q   <= r0;
      spare_q <= r1;
    end
  end

endmodule
